/* hw/rtl/fpa_pkg.sv */
`default_nettype none

package fpa_pkg;

  // fixed geometry of the register map and payload
  localparam int SLOTS            = 4;
  localparam int NUM_PARTITIONS_D = 4;
  localparam int MAX_PROCESSES_D  = 128;

  localparam int SIZE_W   = 8;
  localparam int PID_W    = 7;
  localparam int OWNER_W  = 8;
  localparam int SLOT_W   = 2;
  localparam int POLICY_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_POLICY  = 3'd0,
    REG_PART_SIZE_0 = 3'd1,
    REG_PART_SIZE_1 = 3'd2,
    REG_PART_SIZE_2 = 3'd3,
    REG_PART_SIZE_3 = 3'd4
  } cfg_reg_t;

  // fit policy codes; the unused code falls back to first fit
  typedef enum logic [POLICY_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } policy_t;

  // request kinds
  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_RELEASE  = 1'b1
  } op_t;

  // result codes
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOT_OWNER = 2'd3
  } status_t;

  localparam logic [SIZE_W-1:0] PART_SIZE_RESET [SLOTS] = '{8'd8, 8'd4, 8'd2, 8'd2};
  localparam logic [POLICY_W-1:0] POLICY_RESET = 2'd0;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/fpa_ctrl.sv */
`default_nettype none

module fpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fpa_pkg::dp_cmd_t         cmd,
  input  wire fpa_pkg::dp_status_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;

  // command decode
  assign in_stall   = (state != S_IDLE);
  assign cmd.load   = in_valid && (state == S_IDLE);
  assign cmd.step   = (state == S_SCAN);
  assign cmd.commit = (state == S_COMMIT) && (!out_valid || !out_stall);

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_last) state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fpa_dp.sv */
`default_nettype none

module fpa_dp #(
  parameter int NUM_PARTITIONS = fpa_pkg::NUM_PARTITIONS_D,
  parameter int MAX_PROCESSES  = fpa_pkg::MAX_PROCESSES_D
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              operation,
  input  wire logic [fpa_pkg::PID_W-1:0]         process_id,
  input  wire logic [fpa_pkg::SIZE_W-1:0]        request_size,
  input  wire fpa_pkg::dp_cmd_t                  cmd,
  output fpa_pkg::dp_status_t                    sts,
  output logic [1:0]                             status,
  output logic [fpa_pkg::SLOT_W-1:0]             partition_index
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam logic [fpa_pkg::SLOT_W-1:0] LAST_SLOT = fpa_pkg::SLOT_W'(NUM_PARTITIONS - 1);
  localparam logic [fpa_pkg::OWNER_W-1:0] PID_LIMIT = fpa_pkg::OWNER_W'(MAX_PROCESSES);

  // configuration registers
  logic [fpa_pkg::POLICY_W-1:0] policy;
  logic [fpa_pkg::SIZE_W-1:0]   part_size [fpa_pkg::SLOTS];

  // owner table, zero marks a free partition
  logic [fpa_pkg::OWNER_W-1:0]  owner [NUM_PARTITIONS];

  // request being worked on
  logic                         op_q;
  logic [fpa_pkg::PID_W-1:0]    pid_q;
  logic [fpa_pkg::SIZE_W-1:0]   need_q;

  // scan state
  logic [fpa_pkg::SLOT_W-1:0]   cnt;
  logic                         found;
  logic [fpa_pkg::SLOT_W-1:0]   pick;
  logic [fpa_pkg::SIZE_W-1:0]   key;

  // result register
  fpa_pkg::status_t             status_q;
  logic [fpa_pkg::SLOT_W-1:0]   index_q;

  logic [fpa_pkg::OWNER_W-1:0]  tag;
  logic [fpa_pkg::OWNER_W-1:0]  own_cur;
  logic [fpa_pkg::SIZE_W-1:0]   size_cur;
  logic [fpa_pkg::SIZE_W-1:0]   left_cur;
  logic                         fits;
  logic                         better;
  logic                         take;
  logic [fpa_pkg::SIZE_W-1:0]   key_cur;
  logic                         pid_ok;

  assign tag      = fpa_pkg::OWNER_W'(pid_q) + 1'b1;
  assign own_cur  = owner[cnt[IDX_W-1:0]];
  assign size_cur = part_size[cnt];
  assign left_cur = size_cur - need_q;
  assign fits     = (own_cur == '0) && (size_cur >= need_q);
  assign pid_ok   = {1'b0, pid_q} < PID_LIMIT;

  // per-entry candidate test: fit policy on allocate, owner match on release
  always_comb begin
    better  = !found;
    key_cur = size_cur;
    if (policy == fpa_pkg::FIT_BEST) begin
      better  = !found || (left_cur < key);
      key_cur = left_cur;
    end else if (policy == fpa_pkg::FIT_WORST) begin
      better  = !found || (size_cur > key);
    end
    if (op_q == fpa_pkg::OP_RELEASE) begin
      take = !found && (own_cur == tag);
    end else begin
      take = fits && better;
    end
  end

  assign sts.scan_last = (cnt == LAST_SLOT);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= fpa_pkg::POLICY_RESET;
      for (int i = 0; i < fpa_pkg::SLOTS; i++) begin
        part_size[i] <= fpa_pkg::PART_SIZE_RESET[i];
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        fpa_pkg::REG_FIT_POLICY:  policy       <= cfg_data[fpa_pkg::POLICY_W-1:0];
        fpa_pkg::REG_PART_SIZE_0: part_size[0] <= cfg_data;
        fpa_pkg::REG_PART_SIZE_1: part_size[1] <= cfg_data;
        fpa_pkg::REG_PART_SIZE_2: part_size[2] <= cfg_data;
        fpa_pkg::REG_PART_SIZE_3: part_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture and scan, one partition per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      pid_q  <= process_id;
      need_q <= request_size;
      cnt    <= '0;
      found  <= 1'b0;
      pick   <= '0;
      key    <= '0;
    end else if (cmd.step) begin
      if (take) begin
        found <= 1'b1;
        pick  <= cnt;
        key   <= key_cur;
      end
      if (!sts.scan_last) cnt <= cnt + 1'b1;
    end
  end

  // owner table update and result on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PARTITIONS; i++) begin
        owner[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (pid_ok && found) begin
        if (op_q == fpa_pkg::OP_RELEASE) begin
          owner[pick[IDX_W-1:0]] <= '0;
          status_q               <= fpa_pkg::ST_RELEASED;
        end else begin
          owner[pick[IDX_W-1:0]] <= tag;
          status_q               <= fpa_pkg::ST_ALLOCATED;
        end
        index_q <= pick;
      end else begin
        status_q <= (op_q == fpa_pkg::OP_RELEASE) ? fpa_pkg::ST_NOT_OWNER
                                                   : fpa_pkg::ST_NO_FIT;
        index_q  <= '0;
      end
    end
  end

  assign status          = status_q;
  assign partition_index = index_q;

endmodule

`default_nettype wire

/* hw/rtl/fixed_partition_allocator.sv */
// channel   signals                                        direction
// cfg       cfg_write, cfg_index[2:0], cfg_data[7:0]       in, write only
// in        in_valid, in_stall, operation, process_id,     in, stall out
//           request_size
// out       out_valid, out_stall, status, partition_index  out, stall in
//
// after accept, one partition is examined per cycle by the scan, then a
// commit cycle updates the owner table and loads the result register.
// a new item is accepted the cycle after commit, even while the last result
// is still held; commit waits only while that result is stalled.
// rst is synchronous: all partitions free, configuration registers at their reset values.
`default_nettype none

module fixed_partition_allocator #(
  parameter int NUM_PARTITIONS = fpa_pkg::NUM_PARTITIONS_D,
  parameter int MAX_PROCESSES  = fpa_pkg::MAX_PROCESSES_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           operation,
  input  wire logic [fpa_pkg::PID_W-1:0]      process_id,
  input  wire logic [fpa_pkg::SIZE_W-1:0]     request_size,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          status,
  output logic [fpa_pkg::SLOT_W-1:0]          partition_index
);

  fpa_pkg::dp_cmd_t    cmd;
  fpa_pkg::dp_status_t sts;

  // sequencing
  fpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // owner table, scan and result
  fpa_dp #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .MAX_PROCESSES  (MAX_PROCESSES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .operation       (operation),
    .process_id      (process_id),
    .request_size    (request_size),
    .cmd             (cmd),
    .sts             (sts),
    .status          (status),
    .partition_index (partition_index)
  );

endmodule

`default_nettype wire

/* hw/rtl/fpa_checker.sv */
`default_nettype none

module fpa_checker #(
  parameter int NUM_PARTITIONS = fpa_pkg::NUM_PARTITIONS_D
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [1:0]                        status,
  input wire logic [fpa_pkg::SLOT_W-1:0]        partition_index
);

  localparam logic [fpa_pkg::SLOT_W:0] NP = (fpa_pkg::SLOT_W + 1)'(NUM_PARTITIONS);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(partition_index))
    else $error("result beat changed while stalled");

  // an accepted beat blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // failed requests report partition zero
  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fpa_pkg::ST_NO_FIT || status == fpa_pkg::ST_NOT_OWNER)
      |-> partition_index == '0)
    else $error("nonzero partition on a failed request");

  // granted or freed partition exists
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, partition_index} < NP)
    else $error("partition index beyond partition count");

endmodule

bind fixed_partition_allocator fpa_checker #(
  .NUM_PARTITIONS (NUM_PARTITIONS)
) u_fpa_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .partition_index (partition_index)
);

`default_nettype wire

/* tb/sv/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // unused policy code, handled as first fit
  localparam logic [fpa_pkg::POLICY_W-1:0] FIT_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    fpa_pkg::op_t                 op;
    logic [fpa_pkg::PID_W-1:0]    pid;
    logic [fpa_pkg::SIZE_W-1:0]   need;
  } request_t;

  typedef struct packed {
    fpa_pkg::status_t             status;
    logic [fpa_pkg::SLOT_W-1:0]   slot;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [fpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [fpa_pkg::PID_W-1:0] process_id = '0;
  logic [fpa_pkg::SIZE_W-1:0] request_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [fpa_pkg::SLOT_W-1:0] partition_index;

  fixed_partition_allocator uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .process_id     (process_id),
    .request_size   (request_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .partition_index(partition_index)
  );

  // mirror of the allocator state
  logic [fpa_pkg::POLICY_W-1:0] fit_mode = fpa_pkg::POLICY_RESET;
  logic [fpa_pkg::SIZE_W-1:0]   size_kb [fpa_pkg::SLOTS] = fpa_pkg::PART_SIZE_RESET;
  logic [fpa_pkg::OWNER_W-1:0]  owner   [fpa_pkg::SLOTS] = '{default: '0};

  request_t pending_q[$];
  grant_t   grant_q[$];
  int       mismatch_count = 0;

  // idling odds in percent, changed only between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #1 clk = ~clk;

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    mismatch_count++;
  endtask

  // expected outcome of one request; updates the owner mirror
  function automatic grant_t serve_request(request_t r);
    grant_t                      g;
    int                          pick;
    int                          key;
    int                          room;
    logic [fpa_pkg::OWNER_W-1:0] tag;
    g.status = fpa_pkg::ST_NO_FIT;
    g.slot   = '0;
    pick     = -1;
    key      = 0;
    tag      = fpa_pkg::OWNER_W'(r.pid) + 1'b1;
    if (int'(r.pid) >= fpa_pkg::MAX_PROCESSES_D) begin
      g.status = (r.op == fpa_pkg::OP_RELEASE) ? fpa_pkg::ST_NOT_OWNER
                                                : fpa_pkg::ST_NO_FIT;
    end else if (r.op == fpa_pkg::OP_ALLOCATE) begin
      for (int i = 0; i < fpa_pkg::NUM_PARTITIONS_D; i++) begin
        if (owner[i] == '0 && size_kb[i] >= r.need) begin
          room = int'(size_kb[i]) - int'(r.need);
          case (fit_mode)
            fpa_pkg::FIT_BEST: begin
              if (pick < 0 || room < key) begin
                pick = i;
                key  = room;
              end
            end
            fpa_pkg::FIT_WORST: begin
              if (pick < 0 || int'(size_kb[i]) > key) begin
                pick = i;
                key  = int'(size_kb[i]);
              end
            end
            default: begin
              if (pick < 0) pick = i;
            end
          endcase
        end
      end
      if (pick >= 0) begin
        owner[pick] = tag;
        g.status    = fpa_pkg::ST_ALLOCATED;
        g.slot      = fpa_pkg::SLOT_W'(pick);
      end
    end else begin
      g.status = fpa_pkg::ST_NOT_OWNER;
      for (int i = 0; i < fpa_pkg::NUM_PARTITIONS_D; i++) begin
        if (g.status == fpa_pkg::ST_NOT_OWNER && owner[i] == tag) begin
          owner[i] = '0;
          g.status = fpa_pkg::ST_RELEASED;
          g.slot   = fpa_pkg::SLOT_W'(i);
        end
      end
    end
    return g;
  endfunction

  // request driver, one beat per handshake
  logic     in_beat_done = 1'b0;
  int       send_gap = 0;
  logic     next_valid;
  request_t next_req;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (!in_valid || in_beat_done) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          if ($urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(1, 9) - 1;
          end else begin
            next_req     = pending_q.pop_front();
            operation    <= next_req.op;
            process_id   <= next_req.pid;
            request_size <= next_req.need;
            next_valid   = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // result-side stall bursts
  int hold_gap = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_gap > 0) begin
      hold_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < recv_stall_pct) begin
      hold_gap = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on accepted requests, check accepted results
  request_t seen_req;
  grant_t   want;

  always @(posedge clk) begin
    in_beat_done = !rst && in_valid && !in_stall;
    if (in_beat_done) begin
      seen_req.op   = fpa_pkg::op_t'(operation);
      seen_req.pid  = process_id;
      seen_req.need = request_size;
      grant_q.push_back(serve_request(seen_req));
    end
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result beat", 8'(status), 8'd0);
      end else begin
        want = grant_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", 8'(status), 8'(want.status));
        if (partition_index !== want.slot)
          report_mismatch("partition_index", 8'(partition_index), 8'(want.slot));
      end
    end
  end

  task automatic push_req(fpa_pkg::op_t op, int pid, int need);
    request_t r;
    r.op   = op;
    r.pid  = fpa_pkg::PID_W'(pid);
    r.need = fpa_pkg::SIZE_W'(need);
    pending_q.push_back(r);
  endtask

  // mostly a small pool of processes so that releases find owners
  task automatic push_random(int count);
    request_t r;
    for (int n = 0; n < count; n++) begin
      r.op = ($urandom_range(0, 99) < 55) ? fpa_pkg::OP_ALLOCATE : fpa_pkg::OP_RELEASE;
      if ($urandom_range(0, 99) < 80) r.pid = fpa_pkg::PID_W'($urandom_range(0, 5));
      else r.pid = fpa_pkg::PID_W'($urandom_range(0, 127));
      case ($urandom_range(0, 3))
        0: r.need = fpa_pkg::SIZE_W'($urandom_range(0, 3));
        1: r.need = fpa_pkg::SIZE_W'($urandom_range(0, 12));
        2: r.need = fpa_pkg::SIZE_W'($urandom_range(0, 255));
        default: r.need = size_kb[$urandom_range(0, 3)]
                          + fpa_pkg::SIZE_W'($urandom_range(0, 2)) - 1'b1;
      endcase
      pending_q.push_back(r);
    end
  endtask

  // wait until every request is sent and every result is back
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(fpa_pkg::cfg_reg_t idx, logic [fpa_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == fpa_pkg::REG_FIT_POLICY) fit_mode = value[fpa_pkg::POLICY_W-1:0];
    else size_kb[int'(idx) - 1] = value;
  endtask

  task automatic run_phase(logic [fpa_pkg::POLICY_W-1:0] policy,
                           int s0, int s1, int s2, int s3,
                           int count, int idle_pct, int stall_pct);
    drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(fpa_pkg::REG_FIT_POLICY, fpa_pkg::CFG_DATA_W'(policy));
    write_reg(fpa_pkg::REG_PART_SIZE_0, fpa_pkg::CFG_DATA_W'(s0));
    write_reg(fpa_pkg::REG_PART_SIZE_1, fpa_pkg::CFG_DATA_W'(s1));
    write_reg(fpa_pkg::REG_PART_SIZE_2, fpa_pkg::CFG_DATA_W'(s2));
    write_reg(fpa_pkg::REG_PART_SIZE_3, fpa_pkg::CFG_DATA_W'(s3));
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    push_random(count);
  endtask

  // stimulus sequence
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct  = 20;
    recv_stall_pct = 20;

    // reset sizes 8 4 2 2 under first fit: fill, overflow, release
    push_req(fpa_pkg::OP_ALLOCATE, 0, 0);
    push_req(fpa_pkg::OP_ALLOCATE, 0, 2);
    push_req(fpa_pkg::OP_ALLOCATE, 127, 2);
    push_req(fpa_pkg::OP_ALLOCATE, 5, 3);
    push_req(fpa_pkg::OP_ALLOCATE, 5, 2);
    push_req(fpa_pkg::OP_ALLOCATE, 6, 0);
    push_req(fpa_pkg::OP_RELEASE, 0, 255);
    push_req(fpa_pkg::OP_RELEASE, 0, 0);
    push_req(fpa_pkg::OP_RELEASE, 0, 17);
    push_req(fpa_pkg::OP_ALLOCATE, 1, 255);
    push_req(fpa_pkg::OP_ALLOCATE, 1, 8);
    push_req(fpa_pkg::OP_RELEASE, 127, 0);
    push_req(fpa_pkg::OP_RELEASE, 5, 128);
    push_req(fpa_pkg::OP_RELEASE, 1, 1);
    push_req(fpa_pkg::OP_RELEASE, 127, 255);
    push_req(fpa_pkg::OP_ALLOCATE, 42, 1);
    push_req(fpa_pkg::OP_ALLOCATE, 85, 4);
    push_req(fpa_pkg::OP_RELEASE, 42, 0);
    push_req(fpa_pkg::OP_RELEASE, 85, 0);
    push_random(350);

    run_phase(fpa_pkg::FIT_BEST,  10, 6, 6, 3, 250, 30, 30);
    run_phase(fpa_pkg::FIT_WORST, 4, 9, 9, 1, 250, 10, 40);
    run_phase(FIT_SPARE, 255, 1, 128, 127, 250, 0, 0);
    // zero-sized partitions take zero-sized requests
    run_phase(fpa_pkg::FIT_WORST, 0, 255, 1, 0, 250, 40, 10);
    run_phase(fpa_pkg::FIT_BEST,  1, 1, 1, 1, 200, 25, 25);
    run_phase(fpa_pkg::FIT_FIRST, 255, 255, 255, 255, 200, 15, 35);
    // final stretch without idling
    run_phase(fpa_pkg::FIT_BEST,  3, 0, 5, 2, 200, 0, 0);
    drain();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

/* fixed_partition_allocator.f */
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_ctrl.sv
hw/rtl/fpa_dp.sv
hw/rtl/fixed_partition_allocator.sv
hw/rtl/fpa_checker.sv
tb/sv/tb.sv
